/* hdl/bli_pkg.sv */
// Shared types and constants for the battery LED indicator.
// Depends on nothing; used by battery_led_indicator_top.
package bli_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_CRITICAL_LEVEL     = 3'd0;
    localparam logic [2:0] CFG_LOW_LEVEL          = 3'd1;
    localparam logic [2:0] CFG_CRITICAL_FADE_STEP = 3'd2;
    localparam logic [2:0] CFG_LOW_FADE_STEP      = 3'd3;
    localparam logic [2:0] CFG_HOLD_TICKS         = 3'd4;
    localparam logic [2:0] CFG_BLINK_ON_TICKS     = 3'd5;

    // Charge state codes.
    localparam logic [2:0] CS_CHARGE      = 3'd0;
    localparam logic [2:0] CS_DISCHARGE   = 3'd1;
    localparam logic [2:0] CS_ERROR       = 3'd2;
    localparam logic [2:0] CS_NEAR_FULL   = 3'd3;
    localparam logic [2:0] CS_IDLE        = 3'd4;
    localparam logic [2:0] CS_FORCED_IDLE = 3'd5;

    // Request kinds carried on tuser.
    localparam logic REQ_STATUS = 1'b0;
    localparam logic REQ_PULSE  = 1'b1;

    // Field widths and duty constants.
    localparam int DUTY_W  = 7;
    localparam int HOLD_W  = 4;
    localparam int BLINK_W = 5;
    localparam int COUNT_W = 32;
    localparam logic [DUTY_W-1:0] FULL_DUTY = 7'd100;
    localparam logic [DUTY_W-1:0] ZERO_DUTY = 7'd0;

    // One result: the duty of both colours.
    typedef struct packed {
        logic [DUTY_W-1:0] amber;
        logic [DUTY_W-1:0] white;
    } duty_pair_t;

endpackage

/* hdl/battery_led_indicator_top.sv */
// Battery LED indicator: one-stage update of LED duties per status or pulse request.
// Depends on bli_pkg for codes, widths and the duty pair type.
//
// Usage:
//   Requests arrive on the s_ channel. s_tuser selects a slow status tick (0) or
//   a fast pulse tick (1); s_tdata carries charge state, battery percent and the
//   auto-enable bit. A request that drives the LED gives one result on the m_
//   channel with the white and amber duty in percent; other requests give none.
//   Each request is held in an input register, evaluated against the pulse and
//   tick state, and its result lands in the output register, which drives m_tvalid.
//   One request is taken every cycle while the output register is free or being
//   drained, or while the held request gives no result.
//   The blink phase runs in its own small counter beside the 32-bit tick count,
//   so no divider sits in the update path.
//   When the receiver stalls, the waiting result holds and the input register
//   keeps its request; requests that produce no result still pass through.
//   s_tready then falls once both registers are occupied. Reset (aresetn low at a
//   clock edge) clears the pulse state, the tick count, both valid flags, and
//   loads the configuration defaults. The user must write configuration through
//   cfg_wr_en, cfg_addr and cfg_wr_data only while idle; the block does not check.
module battery_led_indicator_top #(
    parameter int BLINK_PERIOD = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Request channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // [2:0] chg_mode, [9:3] battery_percent,
                                  // [10] auto_enabled, [15:11] zero
    input  logic        s_tuser,  // [0] req_type
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,  // [6:0] white_duty, [13:7] amber_duty, [15:14] zero
    // Configuration port.
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [6:0]  cfg_wr_data
);

    localparam int PH_W = (BLINK_PERIOD > 2) ? $clog2(BLINK_PERIOD) : 1;
    localparam logic [PH_W-1:0] PH_LAST = PH_W'(BLINK_PERIOD - 1);

    // Configuration registers.
    logic [bli_pkg::DUTY_W-1:0]  critical_level_reg;
    logic [bli_pkg::DUTY_W-1:0]  low_level_reg;
    logic [bli_pkg::DUTY_W-1:0]  critical_fade_step_reg;
    logic [bli_pkg::DUTY_W-1:0]  low_fade_step_reg;
    logic [bli_pkg::HOLD_W-1:0]  hold_ticks_reg;
    logic [bli_pkg::BLINK_W-1:0] blink_on_ticks_reg;

    // Input register.
    logic                       in_valid_reg;
    logic                       in_req_reg;
    logic [2:0]                 in_cs_reg;
    logic [bli_pkg::DUTY_W-1:0] in_pct_reg;
    logic                       in_auto_reg;

    // Indicator state.
    logic [bli_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [PH_W-1:0]             phase_reg, phase_next;
    logic                        low_armed_reg, low_armed_next;
    logic                        critical_armed_reg, critical_armed_next;
    logic                        running_reg, running_next;
    logic [bli_pkg::DUTY_W-1:0]  duty_reg, duty_next;
    logic [bli_pkg::DUTY_W-1:0]  step_reg, step_next;
    logic [bli_pkg::HOLD_W-1:0]  hold_left_reg, hold_left_next;

    // Output register.
    logic                m_valid_reg;
    bli_pkg::duty_pair_t m_duty_reg;

    // Evaluation results.
    logic                res_valid;
    bli_pkg::duty_pair_t res_duty;
    logic                advance;

    // The request in the input register moves on when its result has room.
    assign advance  = in_valid_reg && (!res_valid || !m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_duty_reg.amber, m_duty_reg.white};

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            critical_level_reg     <= 7'd5;
            low_level_reg          <= 7'd8;
            critical_fade_step_reg <= 7'd7;
            low_fade_step_reg      <= 7'd3;
            hold_ticks_reg         <= 4'd5;
            blink_on_ticks_reg     <= 5'd2;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                bli_pkg::CFG_CRITICAL_LEVEL:     critical_level_reg     <= cfg_wr_data;
                bli_pkg::CFG_LOW_LEVEL:          low_level_reg          <= cfg_wr_data;
                bli_pkg::CFG_CRITICAL_FADE_STEP: critical_fade_step_reg <= cfg_wr_data;
                bli_pkg::CFG_LOW_FADE_STEP:      low_fade_step_reg      <= cfg_wr_data;
                bli_pkg::CFG_HOLD_TICKS:         hold_ticks_reg <= cfg_wr_data[3:0];
                bli_pkg::CFG_BLINK_ON_TICKS:     blink_on_ticks_reg <= cfg_wr_data[4:0];
                default: ;
            endcase
        end
    end

    // Input register: capture a request whenever the stage is free.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_req_reg  <= s_tuser;
            in_cs_reg   <= s_tdata[2:0];
            in_pct_reg  <= s_tdata[9:3];
            in_auto_reg <= s_tdata[10];
        end
    end

    // One-pass evaluation of the request against the indicator state.
    always_comb begin
        logic [bli_pkg::COUNT_W-1:0] cnt_inc;
        logic [PH_W-1:0]             ph_inc;
        logic                        lit_blink;

        cnt_inc = count_reg + 32'd1;
        // The phase follows the count modulo the blink period, and restarts when
        // the count wraps to zero.
        if (&count_reg) begin
            ph_inc = '0;
        end else if (phase_reg == PH_LAST) begin
            ph_inc = '0;
        end else begin
            ph_inc = phase_reg + PH_W'(1);
        end
        lit_blink = (bli_pkg::BLINK_W'(ph_inc) < blink_on_ticks_reg);

        count_next          = count_reg;
        phase_next          = phase_reg;
        low_armed_next      = low_armed_reg;
        critical_armed_next = critical_armed_reg;
        running_next        = running_reg;
        duty_next           = duty_reg;
        step_next           = step_reg;
        hold_left_next      = hold_left_reg;
        res_valid           = 1'b0;
        res_duty.white      = bli_pkg::ZERO_DUTY;
        res_duty.amber      = bli_pkg::ZERO_DUTY;

        if (in_req_reg == bli_pkg::REQ_PULSE) begin
            // Pulse tick: jump to full duty, hold, then fade.
            priority if (!running_reg) begin
                res_valid = 1'b0;
            end else if (hold_left_reg != '0) begin
                hold_left_next = hold_left_reg - 4'd1;
            end else if (!in_auto_reg) begin
                res_valid = 1'b0;
            end else if (duty_reg == bli_pkg::ZERO_DUTY) begin
                duty_next      = bli_pkg::FULL_DUTY;
                hold_left_next = (hold_ticks_reg != '0) ? hold_ticks_reg - 4'd1 : 4'd0;
                res_valid      = 1'b1;
                res_duty.amber = bli_pkg::FULL_DUTY;
            end else if (step_reg > duty_reg) begin
                duty_next      = bli_pkg::ZERO_DUTY;
                res_valid      = 1'b1;
                res_duty.amber = bli_pkg::ZERO_DUTY;
            end else begin
                duty_next      = duty_reg - step_reg;
                res_valid      = 1'b1;
                res_duty.amber = duty_reg - step_reg;
            end
        end else begin
            // Status tick: advance the count, then pick the colour.
            count_next = cnt_inc;
            phase_next = ph_inc;
            unique case (in_cs_reg)
                bli_pkg::CS_CHARGE: begin
                    res_valid      = in_auto_reg;
                    res_duty.amber = bli_pkg::FULL_DUTY;
                end
                bli_pkg::CS_DISCHARGE: begin
                    if (!in_auto_reg) begin
                        low_armed_next      = 1'b0;
                        critical_armed_next = 1'b0;
                        running_next        = 1'b0;
                    end else if (in_pct_reg <= critical_level_reg && !critical_armed_reg) begin
                        low_armed_next      = 1'b0;
                        critical_armed_next = 1'b1;
                        step_next           = critical_fade_step_reg;
                        duty_next           = bli_pkg::ZERO_DUTY;
                        hold_left_next      = '0;
                        running_next        = 1'b1;
                    end else if (in_pct_reg <= low_level_reg
                                 && in_pct_reg > critical_level_reg && !low_armed_reg) begin
                        critical_armed_next = 1'b0;
                        low_armed_next      = 1'b1;
                        step_next           = low_fade_step_reg;
                        duty_next           = bli_pkg::ZERO_DUTY;
                        hold_left_next      = '0;
                        running_next        = 1'b1;
                    end else if (in_pct_reg > low_level_reg
                                 && !critical_armed_reg && !low_armed_reg) begin
                        running_next = 1'b0;
                        res_valid    = 1'b1;
                    end
                end
                bli_pkg::CS_ERROR: begin
                    res_valid      = in_auto_reg;
                    res_duty.amber = cnt_inc[0] ? bli_pkg::FULL_DUTY : bli_pkg::ZERO_DUTY;
                end
                bli_pkg::CS_NEAR_FULL, bli_pkg::CS_IDLE: begin
                    res_valid      = in_auto_reg;
                    res_duty.white = bli_pkg::FULL_DUTY;
                end
                bli_pkg::CS_FORCED_IDLE: begin
                    res_valid      = in_auto_reg;
                    res_duty.amber = lit_blink ? bli_pkg::FULL_DUTY : bli_pkg::ZERO_DUTY;
                end
                default: ;
            endcase
            // Any state but discharge disarms the pulse.
            if (in_cs_reg != bli_pkg::CS_DISCHARGE) begin
                low_armed_next      = 1'b0;
                critical_armed_next = 1'b0;
                running_next        = 1'b0;
            end
        end
    end

    // State update as the request leaves the input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg          <= '0;
            phase_reg          <= '0;
            low_armed_reg      <= 1'b0;
            critical_armed_reg <= 1'b0;
            running_reg        <= 1'b0;
            duty_reg           <= '0;
            step_reg           <= '0;
            hold_left_reg      <= '0;
        end else if (advance) begin
            count_reg          <= count_next;
            phase_reg          <= phase_next;
            low_armed_reg      <= low_armed_next;
            critical_armed_reg <= critical_armed_next;
            running_reg        <= running_next;
            duty_reg           <= duty_next;
            step_reg           <= step_next;
            hold_left_reg      <= hold_left_next;
        end
    end

    // Output register: load a new result, or drain the one that was taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            m_duty_reg <= res_duty;
        end
    end

    // Only one of the two pulse kinds may be armed at a time.
    a_armed_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(low_armed_reg && critical_armed_reg))
        else $error("low and critical pulse armed together");

    // An armed pulse is always running.
    a_armed_running: assert property (@(posedge aclk) disable iff (!aresetn)
        (low_armed_reg || critical_armed_reg) |-> running_reg)
        else $error("pulse armed but not running");

    // The pulse duty never exceeds full duty.
    a_duty_range: assert property (@(posedge aclk) disable iff (!aresetn)
        duty_reg <= bli_pkg::FULL_DUTY)
        else $error("pulse duty above full");

    // The blink phase stays inside the blink period.
    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg <= PH_LAST)
        else $error("blink phase out of range");

    // A held request only waits behind a result that is stalled.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |-> (m_valid_reg && !m_tready && res_valid))
        else $error("input register stalled without a blocked result");

endmodule
